@@ rtl/mpbss_pkg.sv @@
`timescale 1ns / 1ps
package mpbss_pkg;

   localparam logic [1:0] MODE_WRITE_BYTE = 2'd0;
   localparam logic [1:0] MODE_SET_LENGTH = 2'd1;
   localparam logic [1:0] MODE_SCAN_BYTE  = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_PATTERN_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] pattern_index;
      logic [5:0] position;
      logic [6:0] pattern_length;
      logic [7:0] value;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  pattern_number;
      logic [31:0] match_offset;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

@@ rtl/multi_pattern_byte_signature_scan.sv @@
`timescale 1ns / 1ps
// Multi-pattern byte signature scan. Signature bytes and lengths are written
// one per request. A region byte keeps the input stalled while it is scanned,
// so a new region byte is taken only after the last is through: the byte is
// shifted into a chain of MAX_PATTERN_BYTES window cells, then the signatures
// are read one per cycle from the signature memory (one row per signature),
// aligned to the window end and compared by all cells at once; a registered
// AND of the cell results records the first hit of each signature. The byte
// marked last is followed by a final step that picks the lowest enabled
// signature that hit, and waits there while an earlier result is still
// stalled in the output register; the result then leaves through that
// register while the next request can already be taken.
// Register pattern_count lies at byte address 0.
module multi_pattern_byte_signature_scan #(
   parameter int NUM_PATTERNS      = 16,
   parameter int MAX_PATTERN_BYTES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mpbss_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mpbss_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mpbss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import mpbss_pkg::*;

   localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CW = $clog2(NUM_PATTERNS + 3);
   localparam int RW = MAX_PATTERN_BYTES * 8;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic         last_ff, last_in;
   logic [31:0]  seen_ff, seen_in;
   logic [4:0]   pcount_ff, pcount_in;
   logic         b_v_ff, c_v_ff;
   logic [PW-1:0] b_p_ff, c_p_ff;
   logic         lenok_ff;
   logic [LW-1:0] len_c_ff;
   logic [NUM_PATTERNS-1:0] hit_ff, hit_in;
   logic [31:0]  hit_off_ff [NUM_PATTERNS];
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         accept;
   logic         a_v;
   logic         scan_done;
   logic         final_go;
   logic         csr_wr;
   logic [RW-1:0] rd_row;
   logic [LW-1:0] rd_len;
   logic [RW-1:0] rev_row;
   logic [RW-1:0] ref_row;
   logic [LW-1:0] sh_bytes;
   logic         lenok_in;
   logic [MAX_PATTERN_BYTES-1:0] match_bits;
   logic [7:0]   chain [MAX_PATTERN_BYTES+1];
   cell_ctl_type cell_ctl;
   logic         c_hit;
   logic [PW-1:0] pick;
   logic         any_hit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign a_v       = (state_ff == ST_SCAN) && (32'(cnt_ff) < NUM_PATTERNS);
   assign scan_done = (state_ff == ST_SCAN) && (32'(cnt_ff) == NUM_PATTERNS + 2);
   assign final_go  = (state_ff == ST_FINAL) && (!rsp_valid_ff || !rsp_stall);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   mpbss_sig_store #(
      .NUM_PATTERNS      (NUM_PATTERNS),
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .PW                (PW),
      .LW                (LW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_byte  (accept && req_data.mode == MODE_WRITE_BYTE),
      .wr_len   (accept && req_data.mode == MODE_SET_LENGTH),
      .wr_idx   (req_data.pattern_index),
      .wr_pos   (req_data.position),
      .wr_value (req_data.value),
      .wr_plen  (req_data.pattern_length),
      .rd_addr  (cnt_ff[PW-1:0]),
      .rd_row   (rd_row),
      .rd_len   (rd_len)
   );

   // cell r must see signature byte len-1-r: reverse the row, then drop
   // the bytes past the signature end
   always_comb begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         rev_row[i*8 +: 8] = rd_row[(MAX_PATTERN_BYTES-1-i)*8 +: 8];
      end
      sh_bytes = LW'(MAX_PATTERN_BYTES) - rd_len;
      ref_row  = rev_row >> {sh_bytes, 3'b000};
      lenok_in = (rd_len != '0) && (({1'b0, seen_ff} + 33'd1) >= 33'(rd_len));
   end

   assign cell_ctl.shift = accept && (req_data.mode == MODE_SCAN_BYTE);
   assign cell_ctl.clear = final_go;
   assign chain[0]       = req_data.value;

   for (genvar r = 0; r < MAX_PATTERN_BYTES; r++) begin : g_cell
      mpbss_cell #(
         .IDX (r),
         .LW  (LW)
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .byte_in  (chain[r]),
         .ref_byte (ref_row[r*8 +: 8]),
         .len      (rd_len),
         .byte_out (chain[r+1]),
         .match    (match_bits[r])
      );
   end

   assign c_hit = c_v_ff && lenok_ff && (&match_bits) && !hit_ff[c_p_ff];

   always_comb begin
      pick    = '0;
      any_hit = 1'b0;
      for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
         if (hit_ff[p] && (p < 32'(pcount_ff))) begin
            pick    = PW'(p);
            any_hit = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      pcount_in    = pcount_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr && csr_paddr[2] == CSR_IDX_PATTERN_COUNT) begin
         pcount_in = csr_pwdata[4:0];
      end
      if (c_hit) begin
         hit_in[c_p_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.mode == MODE_SCAN_BYTE) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               last_in  = req_data.last;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (scan_done) begin
               if (seen_ff != 32'hFFFF_FFFF) begin
                  seen_in = seen_ff + 32'd1;
               end
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (final_go) begin
               rsp_valid_in          = 1'b1;
               rsp_in.found          = any_hit;
               rsp_in.pattern_number = any_hit ? 4'(pick) : 4'd0;
               rsp_in.match_offset   = any_hit ? hit_off_ff[pick] : 32'd0;
               seen_in               = '0;
               hit_in                = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         seen_ff      <= '0;
         pcount_ff    <= '0;
         hit_ff       <= '0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         pcount_ff    <= pcount_in;
         hit_ff       <= hit_in;
         b_v_ff       <= a_v;
         c_v_ff       <= b_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_p_ff   <= cnt_ff[PW-1:0];
      c_p_ff   <= b_p_ff;
      lenok_ff <= lenok_in;
      len_c_ff <= rd_len;
      rsp_ff   <= rsp_in;
      if (c_hit) begin
         hit_off_ff[c_p_ff] <= seen_ff - (32'(len_c_ff) - 32'd1);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {27'd0, pcount_ff};

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!b_v_ff && !c_v_ff))
      else $error("compare pipeline busy while idle");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINAL))
      else $error("result raised outside final step");

   a_hits_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(final_go)) |-> (hit_ff == '0 && seen_ff == '0))
      else $error("scan state not cleared after result");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(cnt_ff) <= NUM_PATTERNS + 2))
      else $error("pattern counter overran");

endmodule

@@ rtl/mpbss_cell.sv @@
`timescale 1ns / 1ps
module mpbss_cell #(
   parameter int IDX = 0,
   parameter int LW  = 7
) (
   input  logic                  clock,
   input  mpbss_pkg::cell_ctl_type ctl,
   input  logic [7:0]            byte_in,
   input  logic [7:0]            ref_byte,
   input  logic [LW-1:0]         len,
   output logic [7:0]            byte_out,
   output logic                  match
);
   import mpbss_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_w;
   logic       match_ff;
   logic       match_in;

   always_comb begin
      byte_in_w = byte_ff;
      if (ctl.clear) begin
         byte_in_w = 8'd0;
      end else if (ctl.shift) begin
         byte_in_w = byte_in;
      end
      // positions at or beyond the signature length do not take part
      match_in = (32'(len) <= IDX) || (ref_byte == byte_ff);
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in_w;
      match_ff <= match_in;
   end

   assign byte_out = byte_ff;
   assign match    = match_ff;

endmodule

@@ rtl/mpbss_sig_store.sv @@
`timescale 1ns / 1ps
module mpbss_sig_store #(
   parameter int NUM_PATTERNS      = 16,
   parameter int MAX_PATTERN_BYTES = 64,
   parameter int PW                = 4,
   parameter int LW                = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_byte,
   input  logic                           wr_len,
   input  logic [3:0]                     wr_idx,
   input  logic [5:0]                     wr_pos,
   input  logic [7:0]                     wr_value,
   input  logic [6:0]                     wr_plen,
   input  logic [PW-1:0]                  rd_addr,
   output logic [MAX_PATTERN_BYTES*8-1:0] rd_row,
   output logic [LW-1:0]                  rd_len
);
   import mpbss_pkg::*;

   logic [MAX_PATTERN_BYTES*8-1:0] sig_mem [NUM_PATTERNS];
   logic [LW-1:0]                  len_ff [NUM_PATTERNS];
   logic [MAX_PATTERN_BYTES*8-1:0] rd_row_ff;
   logic [LW-1:0]                  rd_len_ff;
   logic                           idx_ok;
   logic                           pos_ok;
   logic [PW-1:0]                  widx;
   logic [LW-1:0]                  clamp_len;

   always_comb begin
      idx_ok = 32'(wr_idx) < NUM_PATTERNS;
      pos_ok = 32'(wr_pos) < MAX_PATTERN_BYTES;
      widx   = PW'(wr_idx);
      if (32'(wr_plen) > MAX_PATTERN_BYTES) begin
         clamp_len = LW'(MAX_PATTERN_BYTES);
      end else begin
         clamp_len = LW'(wr_plen);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_byte && idx_ok && pos_ok) begin
         sig_mem[widx][{wr_pos, 3'b000} +: 8] <= wr_value;
      end
      rd_row_ff <= sig_mem[rd_addr];
      rd_len_ff <= len_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PATTERNS; i++) begin
            len_ff[i] <= '0;
         end
      end else if (wr_len && idx_ok) begin
         len_ff[widx] <= clamp_len;
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_len = rd_len_ff;

endmodule
